// ----- hdl/far_pkg.sv -----
// ----------------------------------------------------------------------------
// far_pkg
// Shared types, constants and the microcode program of the fraction adder.
// ----------------------------------------------------------------------------
package far_pkg;

    localparam int OPERAND_BITS_DEF = 16;
    localparam int NUM_BITS         = 33;
    localparam int DEN_BITS         = 31;
    localparam int PC_BITS          = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL1,
        OP_MUL2,
        OP_ADD,
        OP_MULD,
        OP_GCD,
        OP_DIVI,
        OP_DIV,
        OP_OUT,
        OP_OUTZS,
        OP_OUTZD
    } t_op;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_IF_ZDIV,
        J_IF_ZSUM,
        J_WHILE_GCD,
        J_WHILE_DIV
    } t_jump;

    typedef struct packed {
        t_op                op;
        t_jump              jump;
        logic [PC_BITS-1:0] target;
    } t_ucode;

    // Datapath command for the current step
    typedef struct packed {
        t_op  op;
        logic en;
    } t_ctrl;

    // Datapath flags for the jump logic
    typedef struct packed {
        logic zdiv;
        logic zsum;
        logic gcd_eq;
        logic div_last;
    } t_stat;

    localparam logic [PC_BITS-1:0] ST_LOAD  = 4'd0;
    localparam logic [PC_BITS-1:0] ST_MUL1  = 4'd1;
    localparam logic [PC_BITS-1:0] ST_MUL2  = 4'd2;
    localparam logic [PC_BITS-1:0] ST_ADD   = 4'd3;
    localparam logic [PC_BITS-1:0] ST_MULD  = 4'd4;
    localparam logic [PC_BITS-1:0] ST_GCD   = 4'd5;
    localparam logic [PC_BITS-1:0] ST_DIVI  = 4'd6;
    localparam logic [PC_BITS-1:0] ST_DIV   = 4'd7;
    localparam logic [PC_BITS-1:0] ST_OUT   = 4'd8;
    localparam logic [PC_BITS-1:0] ST_OUTZS = 4'd9;
    localparam logic [PC_BITS-1:0] ST_OUTZD = 4'd10;

    function automatic t_ucode ucode_rom(input logic [PC_BITS-1:0] pc);
        t_ucode w;
        case (pc)
            ST_LOAD:  w = '{OP_LOAD,  J_NEXT,      ST_LOAD};
            ST_MUL1:  w = '{OP_MUL1,  J_IF_ZDIV,   ST_OUTZD};
            ST_MUL2:  w = '{OP_MUL2,  J_NEXT,      ST_LOAD};
            ST_ADD:   w = '{OP_ADD,   J_NEXT,      ST_LOAD};
            ST_MULD:  w = '{OP_MULD,  J_IF_ZSUM,   ST_OUTZS};
            ST_GCD:   w = '{OP_GCD,   J_WHILE_GCD, ST_GCD};
            ST_DIVI:  w = '{OP_DIVI,  J_NEXT,      ST_LOAD};
            ST_DIV:   w = '{OP_DIV,   J_WHILE_DIV, ST_DIV};
            ST_OUT:   w = '{OP_OUT,   J_GOTO,      ST_LOAD};
            ST_OUTZS: w = '{OP_OUTZS, J_GOTO,      ST_LOAD};
            ST_OUTZD: w = '{OP_OUTZD, J_GOTO,      ST_LOAD};
            default:  w = '{OP_NOP,   J_GOTO,      ST_LOAD};
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/far_dp.sv -----
// ----------------------------------------------------------------------------
// far_dp
// Datapath: shared multiplier, signed combine, binary GCD, two-lane divider.
// ----------------------------------------------------------------------------
module far_dp #(
    parameter int OPERAND_BITS = far_pkg::OPERAND_BITS_DEF
) (
    input  logic                              i_clk,
    input  far_pkg::t_ctrl                    i_ctrl,
    input  logic signed [OPERAND_BITS-1:0]    i_first_numerator,
    input  logic signed [OPERAND_BITS-1:0]    i_first_denominator,
    input  logic signed [OPERAND_BITS-1:0]    i_second_numerator,
    input  logic signed [OPERAND_BITS-1:0]    i_second_denominator,
    output far_pkg::t_stat                    o_stat,
    output logic signed [far_pkg::NUM_BITS-1:0] o_sum_numerator,
    output logic [far_pkg::DEN_BITS-1:0]      o_sum_denominator,
    output logic                              o_is_whole,
    output logic                              o_zero_divisor
);
    import far_pkg::*;

    localparam int W  = OPERAND_BITS;
    localparam int MW = 2 * W;
    localparam int KW = $clog2(MW + 1);
    localparam int CW = $clog2(MW);
    localparam int XW = (MW + 1 > NUM_BITS) ? MW + 1 : NUM_BITS;
    localparam int DW = (MW > DEN_BITS) ? MW : DEN_BITS;

    // magnitudes and signs of the operands
    logic [W-1:0]  w_mag_a, w_mag_b, w_mag_c, w_mag_d;
    logic [W-1:0]  r_ma, r_mb, r_mc, r_md;
    logic          r_na, r_nb, r_nc, r_nd;

    logic [W-1:0]  w_mul_x, w_mul_y;
    logic [MW-1:0] w_prod;
    logic [MW-1:0] r_m1, r_m2, r_acc, r_den;
    logic          r_snum, r_neg;
    logic          w_s1, w_s2, w_ssum;
    logic [MW-1:0] w_sum;

    logic [MW-1:0] r_a, r_b, r_g;
    logic [KW-1:0] r_k;
    logic [MW-1:0] n_a, n_b;
    logic [KW-1:0] n_k;

    logic [MW-1:0] r_qn, r_qd, r_rn, r_rd;
    logic [CW-1:0] r_cnt;
    logic [MW:0]   w_rn_sh, w_rd_sh, w_rn_sub, w_rd_sub;
    logic          w_ge_n, w_ge_d;

    logic [XW-1:0] w_qn_x, w_qn_neg;
    logic [DW-1:0] w_qd_x;

    logic signed [NUM_BITS-1:0] r_onum;
    logic [DEN_BITS-1:0]        r_oden;
    logic                       r_owhole, r_ozd;

    assign w_mag_a = i_first_numerator[W-1]    ? (~i_first_numerator + 1'b1)
                                               : i_first_numerator;
    assign w_mag_b = i_first_denominator[W-1]  ? (~i_first_denominator + 1'b1)
                                               : i_first_denominator;
    assign w_mag_c = i_second_numerator[W-1]   ? (~i_second_numerator + 1'b1)
                                               : i_second_numerator;
    assign w_mag_d = i_second_denominator[W-1] ? (~i_second_denominator + 1'b1)
                                               : i_second_denominator;

    always_comb begin
        case (i_ctrl.op)
            OP_MUL1: begin
                w_mul_x = r_ma;
                w_mul_y = r_md;
            end
            OP_MUL2: begin
                w_mul_x = r_mc;
                w_mul_y = r_mb;
            end
            default: begin
                w_mul_x = r_mb;
                w_mul_y = r_md;
            end
        endcase
    end

    assign w_prod = w_mul_x * w_mul_y;

    // sign-magnitude sum of the two cross products
    assign w_s1 = (r_na ^ r_nd) && (r_m1 != '0);
    assign w_s2 = (r_nc ^ r_nb) && (r_m2 != '0);

    always_comb begin
        if (w_s1 == w_s2) begin
            w_sum  = r_m1 + r_m2;
            w_ssum = w_s1;
        end else if (r_m1 >= r_m2) begin
            w_sum  = r_m1 - r_m2;
            w_ssum = w_s1;
        end else begin
            w_sum  = r_m2 - r_m1;
            w_ssum = w_s2;
        end
    end

    // one binary GCD step
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        if (r_a == r_b) begin
            n_a = r_a;
        end else if (!r_a[0] && !r_b[0]) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
            n_k = r_k + 1'b1;
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (r_a > r_b) begin
            n_a = (r_a - r_b) >> 1;
        end else begin
            n_b = (r_b - r_a) >> 1;
        end
    end

    // restoring division, both lanes share the divisor
    assign w_rn_sh  = {r_rn, r_qn[MW-1]};
    assign w_rd_sh  = {r_rd, r_qd[MW-1]};
    assign w_rn_sub = w_rn_sh - {1'b0, r_g};
    assign w_rd_sub = w_rd_sh - {1'b0, r_g};
    assign w_ge_n   = w_rn_sh >= {1'b0, r_g};
    assign w_ge_d   = w_rd_sh >= {1'b0, r_g};

    assign w_qn_x   = XW'(r_qn);
    assign w_qn_neg = ~w_qn_x + 1'b1;
    assign w_qd_x   = DW'(r_qd);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            unique case (i_ctrl.op)
                OP_LOAD: begin
                    r_ma <= w_mag_a;
                    r_mb <= w_mag_b;
                    r_mc <= w_mag_c;
                    r_md <= w_mag_d;
                    r_na <= i_first_numerator[W-1];
                    r_nb <= i_first_denominator[W-1];
                    r_nc <= i_second_numerator[W-1];
                    r_nd <= i_second_denominator[W-1];
                end
                OP_MUL1: r_m1 <= w_prod;
                OP_MUL2: r_m2 <= w_prod;
                OP_ADD: begin
                    r_acc  <= w_sum;
                    r_snum <= w_ssum;
                end
                OP_MULD: begin
                    r_den <= w_prod;
                    r_b   <= w_prod;
                    r_a   <= r_acc;
                    r_k   <= '0;
                    r_neg <= (r_snum ^ r_nb ^ r_nd) && (r_acc != '0);
                end
                OP_GCD: begin
                    r_a <= n_a;
                    r_b <= n_b;
                    r_k <= n_k;
                    r_g <= r_a << r_k;
                end
                OP_DIVI: begin
                    r_qn  <= r_acc;
                    r_qd  <= r_den;
                    r_rn  <= '0;
                    r_rd  <= '0;
                    r_cnt <= '0;
                end
                OP_DIV: begin
                    r_rn  <= w_ge_n ? w_rn_sub[MW-1:0] : w_rn_sh[MW-1:0];
                    r_rd  <= w_ge_d ? w_rd_sub[MW-1:0] : w_rd_sh[MW-1:0];
                    r_qn  <= {r_qn[MW-2:0], w_ge_n};
                    r_qd  <= {r_qd[MW-2:0], w_ge_d};
                    r_cnt <= r_cnt + 1'b1;
                end
                OP_OUT: begin
                    r_onum   <= r_neg ? w_qn_neg[NUM_BITS-1:0] : w_qn_x[NUM_BITS-1:0];
                    r_oden   <= w_qd_x[DEN_BITS-1:0];
                    r_owhole <= (r_qd == MW'(1));
                    r_ozd    <= 1'b0;
                end
                OP_OUTZS: begin
                    r_onum   <= '0;
                    r_oden   <= DEN_BITS'(1);
                    r_owhole <= 1'b1;
                    r_ozd    <= 1'b0;
                end
                OP_OUTZD: begin
                    r_onum   <= '0;
                    r_oden   <= '0;
                    r_owhole <= 1'b0;
                    r_ozd    <= 1'b1;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    assign o_stat.zdiv     = (r_mb == '0) || (r_md == '0);
    assign o_stat.zsum     = (r_acc == '0);
    assign o_stat.gcd_eq   = (r_a == r_b);
    assign o_stat.div_last = (r_cnt == CW'(MW - 1));

    assign o_sum_numerator   = r_onum;
    assign o_sum_denominator = r_oden;
    assign o_is_whole        = r_owhole;
    assign o_zero_divisor    = r_ozd;

endmodule

// ----- hdl/fraction_add_reduce.sv -----
// ----------------------------------------------------------------------------
// fraction_add_reduce - adds two fractions, reduces the sum to lowest terms
// A zero denominator ends after the first multiply, a zero sum after the
// denominator multiply; otherwise the GCD and divide loops follow. One request
// in flight; the next is taken the cycle after its result is registered.
// Sync active-low reset clears the step counter and output valid only.
// ----------------------------------------------------------------------------
module fraction_add_reduce #(
    parameter int OPERAND_BITS = far_pkg::OPERAND_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [OPERAND_BITS-1:0]      i_first_numerator,
    input  logic signed [OPERAND_BITS-1:0]      i_first_denominator,
    input  logic signed [OPERAND_BITS-1:0]      i_second_numerator,
    input  logic signed [OPERAND_BITS-1:0]      i_second_denominator,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [far_pkg::NUM_BITS-1:0] o_sum_numerator,
    output logic [far_pkg::DEN_BITS-1:0]        o_sum_denominator,
    output logic                                o_is_whole,
    output logic                                o_zero_divisor
);
    import far_pkg::*;

    // Sequencer: r_pc addresses the microcode ROM in the package. Each word
    // names one datapath operation and a jump rule. The load step holds until
    // a request arrives; output steps hold while the previous result still
    // sits unread in the output register. Loops (GCD, divide) jump to their
    // own address until the datapath flags say they are done.
    logic [PC_BITS-1:0] r_pc;
    logic               r_ovalid;
    t_ucode             w_uc;
    t_ctrl              w_ctrl;
    t_stat              w_stat;
    logic               w_hold;
    logic               w_jump;
    logic               w_out_step;

    assign w_uc = ucode_rom(r_pc);

    always_comb begin
        w_out_step = 1'b0;
        case (w_uc.op) inside
            OP_LOAD: w_hold = !i_valid;
            OP_OUT, OP_OUTZS, OP_OUTZD: begin
                // result register busy and not being drained this cycle
                w_hold     = r_ovalid && i_stall;
                w_out_step = 1'b1;
            end
            default: w_hold = 1'b0;
        endcase
    end

    always_comb begin
        unique case (w_uc.jump)
            J_NEXT:      w_jump = 1'b0;
            J_GOTO:      w_jump = 1'b1;
            J_IF_ZDIV:   w_jump = w_stat.zdiv;
            J_IF_ZSUM:   w_jump = w_stat.zsum;
            J_WHILE_GCD: w_jump = !w_stat.gcd_eq;
            J_WHILE_DIV: w_jump = !w_stat.div_last;
            default:     w_jump = 1'b1;
        endcase
    end

    assign w_ctrl.op = w_uc.op;
    assign w_ctrl.en = !w_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_LOAD;
        end else if (!w_hold) begin
            r_pc <= w_jump ? w_uc.target : r_pc + 1'b1;
        end
    end

    // Output valid: set when an output step fires, cleared when drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_step && !w_hold) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // Requests are taken only at the load step.
    assign o_stall = (w_uc.op != OP_LOAD);
    assign o_valid = r_ovalid;

    far_dp #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_ctrl              (w_ctrl),
        .i_first_numerator   (i_first_numerator),
        .i_first_denominator (i_first_denominator),
        .i_second_numerator  (i_second_numerator),
        .i_second_denominator(i_second_denominator),
        .o_stat              (w_stat),
        .o_sum_numerator     (o_sum_numerator),
        .o_sum_denominator   (o_sum_denominator),
        .o_is_whole          (o_is_whole),
        .o_zero_divisor      (o_zero_divisor)
    );

    // An accepted request moves the sequencer to the first multiply and
    // closes the input side.
    a_accept_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_stall && r_pc == ST_MUL1))
        else $error("accept did not advance to the multiply step");

    // A fired output step leaves a valid result behind.
    a_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_step && !w_hold) |=> o_valid)
        else $error("output step fired without raising valid");

    // Zero-divisor results carry all-zero payload.
    a_zdiv_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_divisor) |->
            (o_sum_numerator == '0 && o_sum_denominator == '0 && !o_is_whole))
        else $error("zero divisor result with nonzero payload");

    // Whole-number flag matches a unit denominator.
    a_whole_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_whole) |-> (o_sum_denominator == DEN_BITS'(1)))
        else $error("whole flag with denominator other than one");

endmodule
